// File: hdl/prrs_pkg.sv
package prrs_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned CMD_W = 3;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned PRI_W = 2;
  localparam int unsigned CNT_W = 32;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_YIELD = 3'd1,
    CMD_SLEEP = 3'd2,
    CMD_EXIT  = 3'd3,
    CMD_SCHED = 3'd4
  } cmd_e;

  // Slot lifecycle states
  typedef enum logic [ST_W-1:0] {
    SS_UNUSED  = 3'd0,
    SS_READY   = 3'd1,
    SS_RUNNING = 3'd2,
    SS_WAITING = 3'd3,
    SS_TERM    = 3'd4
  } slot_state_e;

  // Sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_SCAN = 2'd1,
    SEQ_DONE = 2'd2
  } seq_state_e;

endpackage

// File: hdl/priority_round_robin_scheduler.sv
// Channel   | valid      | stall       | payload
// ----------+------------+-------------+---------------------------------------------------
// request   | in_valid_i | in_stall_o  | command_i slot_index_i slot_state_i slot_priority_i
// result    | out_valid_o| out_stall_i | picked_valid_o picked_slot_o all_finished_o
//           |            |             | switch_total_o
//
// A slot write or an unknown command goes from accept through the done state into the result register;
// yield, sleep, exit and schedule first pass through the scan, which reads
// one table entry per cycle through a single read port and one priority compare unit.
// in_stall_o stays high from accept until the result loads, so no new request is taken before
// the last one's result has loaded; a result held by out_stall_i delays the next load.
// Reset is asynchronous, active low; per-slot valid bits make unwritten slots read unused.
module priority_round_robin_scheduler
  import prrs_pkg::*;
#(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned LEVELS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [IDX_W-1:0] slot_index_i,
  input  logic [ST_W-1:0]  slot_state_i,
  input  logic [PRI_W-1:0] slot_priority_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             picked_valid_o,
  output logic [IDX_W-1:0] picked_slot_o,
  output logic             all_finished_o,
  output logic [CNT_W-1:0] switch_total_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned PW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Slot table: state and priority memories, valid bits for reset
  logic [ST_W-1:0] st_mem [SLOTS];
  logic [PW-1:0]   pr_mem [SLOTS];
  logic [SLOTS-1:0] st_vld_q, pr_vld_q;

  logic            st_we, pr_we;
  logic [IW-1:0]   st_waddr, pr_waddr;
  logic [ST_W-1:0] st_wdata;
  logic [PW-1:0]   pr_wdata;

  // Sequencer and scan registers
  seq_state_e      state_q, state_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [IW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IW-1:0]   rd_addr_q;
  logic [ST_W-1:0] rd_st_q;
  logic [PW-1:0]   rd_pr_q;
  logic            sched_q, sched_d;
  logic            found_q, found_d;
  logic            live_q, live_d;
  logic [IW-1:0]   best_q, best_d;
  logic [PW-1:0]   best_pr_q, best_pr_d;
  logic [CNT_W-1:0] sw_q, sw_d;

  // Result register
  logic             ov_q, ov_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] ps_q, ps_d;
  logic             af_q, af_d;
  logic [CNT_W-1:0] so_q, so_d;

  logic            in_acc, issue, out_free, wr_legal, cand;
  logic [PW-1:0]   pr_clamp;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    wrap_inc = (a == IW'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (cnt_q != CW'(SLOTS));
  assign out_free   = !ov_q || !out_stall_i;

  // Slot write legality and priority clamp
  assign wr_legal = (int'(slot_index_i) < SLOTS) && (slot_state_i <= SS_TERM);
  assign pr_clamp = (int'(slot_priority_i) >= LEVELS) ? PW'(LEVELS - 1) : PW'(slot_priority_i);

  // Shared compare: ready slot with priority strictly above best so far
  assign cand = rd_vld_q && (rd_st_q == SS_READY) && (!found_q || (rd_pr_q > best_pr_q));

  // Next state, table writes and result load
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    rd_vld_d  = 1'b0;
    sched_d   = sched_q;
    found_d   = found_q;
    live_d    = live_q;
    best_d    = best_q;
    best_pr_d = best_pr_q;
    sw_d      = sw_q;
    ov_d      = ov_q && out_stall_i;
    pv_d      = pv_q;
    ps_d      = ps_q;
    af_d      = af_q;
    so_d      = so_q;
    st_we     = 1'b0;
    pr_we     = 1'b0;
    st_waddr  = cur_q;
    pr_waddr  = IW'(slot_index_i);
    st_wdata  = SS_READY;
    pr_wdata  = pr_clamp;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          ptr_d   = wrap_inc(cur_q);
          cnt_d   = '0;
          found_d = 1'b0;
          live_d  = 1'b0;
          sched_d = 1'b1;
          unique case (command_i)
            CMD_WRITE: begin
              sched_d  = 1'b0;
              st_we    = wr_legal;
              pr_we    = wr_legal;
              st_waddr = IW'(slot_index_i);
              st_wdata = slot_state_i;
            end
            CMD_YIELD: begin
              st_we    = 1'b1;
              st_wdata = SS_READY;
            end
            CMD_SLEEP: begin
              st_we    = 1'b1;
              st_wdata = SS_WAITING;
            end
            CMD_EXIT: begin
              st_we    = 1'b1;
              st_wdata = SS_TERM;
            end
            CMD_SCHED: begin
            end
            default: sched_d = 1'b0;
          endcase
          state_d = sched_d ? SEQ_SCAN : SEQ_DONE;
        end
      end
      SEQ_SCAN: begin
        // one table read issued per cycle, round robin from the slot after current
        if (issue) begin
          ptr_d    = wrap_inc(ptr_q);
          cnt_d    = cnt_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && (rd_st_q != SS_UNUSED) && (rd_st_q != SS_TERM)) begin
          live_d = 1'b1;
        end
        if (cand) begin
          found_d   = 1'b1;
          best_d    = rd_addr_q;
          best_pr_d = rd_pr_q;
        end
        if (!issue && !rd_vld_q) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          pv_d    = 1'b0;
          ps_d    = '0;
          af_d    = 1'b0;
          so_d    = sw_q;
          state_d = SEQ_IDLE;
          if (sched_q && found_q) begin
            st_we    = 1'b1;
            st_waddr = best_q;
            st_wdata = SS_RUNNING;
            cur_d    = best_q;
            sw_d     = sw_q + 1'b1;
            so_d     = sw_q + 1'b1;
            pv_d     = 1'b1;
            ps_d     = IDX_W'(best_q);
          end else if (sched_q) begin
            af_d = !live_q;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Table memory writes
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (pr_we) begin
      pr_mem[pr_waddr] <= pr_wdata;
    end
  end

  // Registered table read; a never-written entry reads as unused, priority zero
  always_ff @(posedge clk_i) begin
    rd_addr_q <= ptr_q;
    rd_st_q   <= st_vld_q[ptr_q] ? st_mem[ptr_q] : SS_UNUSED;
    rd_pr_q   <= pr_vld_q[ptr_q] ? pr_mem[ptr_q] : '0;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      pr_vld_q <= '0;
    end else begin
      if (st_we) st_vld_q[st_waddr] <= 1'b1;
      if (pr_we) pr_vld_q[pr_waddr] <= 1'b1;
    end
  end

  // Control and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      cur_q     <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      sched_q   <= 1'b0;
      found_q   <= 1'b0;
      live_q    <= 1'b0;
      best_q    <= '0;
      best_pr_q <= '0;
      sw_q      <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      sched_q   <= sched_d;
      found_q   <= found_d;
      live_q    <= live_d;
      best_q    <= best_d;
      best_pr_q <= best_pr_d;
      sw_q      <= sw_d;
      ov_q      <= ov_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    pv_q <= pv_d;
    ps_q <= ps_d;
    af_q <= af_d;
    so_q <= so_d;
  end

  assign out_valid_o    = ov_q;
  assign picked_valid_o = pv_q;
  assign picked_slot_o  = ps_q;
  assign all_finished_o = af_q;
  assign switch_total_o = so_q;

endmodule

// File: hdl/prrs_checker.sv
module prrs_checker
  import prrs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CMD_W-1:0] command_i,
  input logic [IDX_W-1:0] slot_index_i,
  input logic [ST_W-1:0]  slot_state_i,
  input logic [PRI_W-1:0] slot_priority_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             picked_valid_o,
  input logic [IDX_W-1:0] picked_slot_o,
  input logic             all_finished_o,
  input logic [CNT_W-1:0] switch_total_o
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(picked_valid_o)
      && $stable(picked_slot_o) && $stable(all_finished_o) && $stable(switch_total_o))
    else $error("stalled result changed");

  // Only one request in flight: stall follows every accepted request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // A pick and the all-finished flag exclude each other
  a_pick_vs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(picked_valid_o && all_finished_o))
    else $error("pick and all_finished both set");

  // A result without a pick reports slot zero
  a_no_pick_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !picked_valid_o |-> picked_slot_o == '0)
    else $error("slot reported without pick");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (.*);
